// ===== hw/rtl/rpd_pkg.sv =====
// Shared types, register codes, reset values and helpers for the RC PWM decoder.
// No dependencies.
package rpd_pkg;

    localparam logic [2:0] CFG_STEER_MIN = 3'd0;
    localparam logic [2:0] CFG_STEER_MAX = 3'd1;
    localparam logic [2:0] CFG_PEDAL_MIN = 3'd2;
    localparam logic [2:0] CFG_PEDAL_MAX = 3'd3;
    localparam logic [2:0] CFG_MARGIN    = 3'd4;
    localparam logic [2:0] CFG_ERR_LIMIT = 3'd5;
    localparam logic [2:0] CFG_STEP_THR  = 3'd6;
    localparam logic [2:0] CFG_WEIGHT    = 3'd7;

    localparam logic [2:0] ALL_FRESH = 3'b111;

    typedef struct packed {
        logic [15:0] steer_min;
        logic [15:0] steer_max;
        logic [15:0] pedal_min;
        logic [15:0] pedal_max;
        logic [15:0] margin;
        logic [7:0]  err_limit;
        logic [7:0]  step_thr;
        logic [7:0]  weight;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        steer_min: 16'd1000, steer_max: 16'd2000,
        pedal_min: 16'd1000, pedal_max: 16'd2000,
        margin: 16'd100, err_limit: 8'd10, step_thr: 8'd2, weight: 8'd128
    };

    typedef enum logic [3:0] {
        S_IDLE, S_FILT_A, S_FILT_B, S_FILT_C, S_DECIDE, S_MAP_SEL,
        S_MUL, S_DIV_GO, S_DIV_WAIT, S_APPLY, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        R_LOW_SAT, R_LOW_LIN, R_MID, R_HIGH_LIN, R_HIGH_SAT
    } t_region;

    function automatic logic in_window(logic [31:0] w, logic [15:0] mn,
                                       logic [15:0] mx, logic [15:0] margin);
        logic signed [33:0] sw;
        logic signed [33:0] lo;
        logic signed [33:0] hi;
        sw = $signed({2'b00, w});
        lo = $signed({18'd0, mn}) - $signed({18'd0, margin});
        hi = $signed({18'd0, mx}) + $signed({18'd0, margin});
        return (sw > lo) && (sw < hi);
    endfunction

    function automatic logic step_over(logic signed [9:0] a, logic signed [9:0] b,
                                       logic [7:0] thr);
        logic signed [10:0] d;
        d = 11'(a) - 11'(b);
        if (d < 0) begin
            d = -d;
        end
        return d > $signed({3'b000, thr});
    endfunction

endpackage

// ===== hw/rtl/rc_pwm_command_decoder_top.sv =====
// RC PWM command decoder: edge capture, window check, IIR filter, mapping.
// Level events and incomplete or failing polls finish in idle. A passing poll filters all
// three channels (9x32 and 8x32 multipliers), skips mapping on excessive errors, else maps
// steering and pedal, linear segments on the 8-step serial divider. One item at a time; the
// output register lets the next item in while a result waits. Synchronous active-low reset
// clears control, filter and held state only. Depends on rpd_pkg, rpd_cfg_regs, rpd_serial_div.
module rc_pwm_command_decoder_top #(
    parameter int TIMER_BITS        = 32,
    parameter int EMERGENCY_LOW_US  = 1000,
    parameter int EMERGENCY_HIGH_US = 2000
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [1:0]        i_channel,
    input  logic              i_level,
    input  logic [31:0]       i_time_us,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [7:0] o_steering,
    output logic [7:0]        o_throttle,
    output logic [7:0]        o_brake,
    output logic              o_emergency
);
    localparam logic [31:0] EM_MID   = 32'((EMERGENCY_LOW_US + EMERGENCY_HIGH_US) / 2);
    localparam logic [15:0] EM_LOW   = 16'(EMERGENCY_LOW_US);
    localparam logic [15:0] EM_HIGH  = 16'(EMERGENCY_HIGH_US);

    rpd_pkg::t_cfg cfg;

    rpd_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    rpd_pkg::t_state  r_state, n_state;
    rpd_pkg::t_region r_region, n_region;

    logic [TIMER_BITS-1:0] r_rise [3];
    logic [TIMER_BITS-1:0] n_rise [3];
    logic [31:0] r_pw [3];
    logic [31:0] n_pw [3];
    logic [31:0] r_filt [3];
    logic [31:0] n_filt [3];
    logic [2:0]  r_fresh, n_fresh;
    logic [8:0]  r_err, n_err;
    logic signed [7:0] r_hs, n_hs;
    logic [7:0]  r_ht, n_ht, r_hb, n_hb;
    logic        r_he, n_he;
    logic [1:0]  r_idx, n_idx;
    logic [40:0] r_prod_a, n_prod_a;
    logic [39:0] r_prod_b, n_prod_b;
    logic [15:0] r_x, n_x, r_d, n_d;
    logic [7:0]  r_span, n_span;
    logic [23:0] r_num, n_num;
    logic        r_ov;
    logic signed [7:0] r_os;
    logic [7:0]  r_ot, r_ob;
    logic        r_oe;

    logic accept, div_start, div_done, load_out;
    logic [7:0] quot;
    logic [41:0] filt_sum;
    logic [8:0]  w_new;
    logic [TIMER_BITS-1:0] pw_diff;

    logic [15:0] mn, mx;
    logic [16:0] mid_sum;
    logic signed [33:0] s_f, s_mn, s_mx, s_lo, s_hi, s_xa, s_d;
    logic signed [9:0] v_s, v_t, v_b;

    rpd_serial_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(r_num), .i_den(r_d), .o_done(div_done), .o_quot(quot)
    );

    assign accept   = i_valid && o_ready;
    assign w_new    = 9'd256 - {1'b0, cfg.weight};
    assign filt_sum = 42'(r_prod_a) + 42'(r_prod_b);
    assign pw_diff  = i_time_us[TIMER_BITS-1:0] - r_rise[i_channel];

    assign mn      = (r_idx == 2'd0) ? cfg.steer_min : cfg.pedal_min;
    assign mx      = (r_idx == 2'd0) ? cfg.steer_max : cfg.pedal_max;
    assign mid_sum = {1'b0, mn} + {1'b0, mx};
    assign s_f     = $signed({2'b00, r_filt[r_idx]});
    assign s_mn    = $signed({18'd0, mn});
    assign s_mx    = $signed({18'd0, mx});
    assign s_lo    = $signed({18'd0, mid_sum[16:1]}) - $signed({19'd0, cfg.margin[15:1]});
    assign s_hi    = $signed({18'd0, mid_sum[16:1]}) + $signed({19'd0, cfg.margin[15:1]});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rpd_pkg::S_IDLE: begin
                if (accept && i_kind && r_fresh == rpd_pkg::ALL_FRESH &&
                    rpd_pkg::in_window(r_pw[0], cfg.steer_min, cfg.steer_max, cfg.margin) &&
                    rpd_pkg::in_window(r_pw[1], cfg.pedal_min, cfg.pedal_max, cfg.margin) &&
                    rpd_pkg::in_window(r_pw[2], EM_LOW, EM_HIGH, cfg.margin)) begin
                    n_state = rpd_pkg::S_FILT_A;
                end
            end
            rpd_pkg::S_FILT_A: n_state = rpd_pkg::S_FILT_B;
            rpd_pkg::S_FILT_B: n_state = rpd_pkg::S_FILT_C;
            rpd_pkg::S_FILT_C:
                n_state = (r_idx == 2'd2) ? rpd_pkg::S_DECIDE : rpd_pkg::S_FILT_A;
            rpd_pkg::S_DECIDE:
                n_state = (r_err > {1'b0, cfg.err_limit}) ? rpd_pkg::S_OUT
                                                           : rpd_pkg::S_MAP_SEL;
            rpd_pkg::S_MAP_SEL:
                n_state = (n_region == rpd_pkg::R_LOW_LIN || n_region == rpd_pkg::R_HIGH_LIN)
                          ? rpd_pkg::S_MUL : rpd_pkg::S_APPLY;
            rpd_pkg::S_MUL:      n_state = rpd_pkg::S_DIV_GO;
            rpd_pkg::S_DIV_GO:   n_state = rpd_pkg::S_DIV_WAIT;
            rpd_pkg::S_DIV_WAIT: if (div_done) n_state = rpd_pkg::S_APPLY;
            rpd_pkg::S_APPLY:
                n_state = (r_idx == 2'd0) ? rpd_pkg::S_MAP_SEL : rpd_pkg::S_OUT;
            rpd_pkg::S_OUT:      if (!r_ov) n_state = rpd_pkg::S_IDLE;
            default:             n_state = rpd_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready   = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            rpd_pkg::S_IDLE:   o_ready   = 1'b1;
            rpd_pkg::S_DIV_GO: div_start = 1'b1;
            rpd_pkg::S_OUT:    load_out  = !r_ov;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_rise = r_rise; n_pw = r_pw; n_filt = r_filt; n_fresh = r_fresh;
        n_err = r_err; n_hs = r_hs; n_ht = r_ht; n_hb = r_hb; n_he = r_he;
        n_idx = r_idx; n_prod_a = r_prod_a; n_prod_b = r_prod_b;
        n_region = r_region; n_x = r_x; n_d = r_d; n_span = r_span; n_num = r_num;
        s_xa = '0; s_d = '0; v_s = '0; v_t = '0; v_b = '0;
        case (r_state)
            rpd_pkg::S_IDLE: begin
                if (accept && !i_kind && i_channel != 2'd3) begin
                    if (i_level) begin
                        n_rise[i_channel] = i_time_us[TIMER_BITS-1:0];
                    end else begin
                        n_pw[i_channel] = 32'(pw_diff);
                        n_fresh[i_channel] = 1'b1;
                    end
                end else if (accept && i_kind && r_fresh == rpd_pkg::ALL_FRESH) begin
                    n_fresh = '0;
                    n_idx   = 2'd0;
                    if (n_state == rpd_pkg::S_FILT_A) begin
                        if (r_err != 9'd0) n_err = r_err - 9'd1;
                    end else if (r_err < {cfg.err_limit, 1'b0}) begin
                        n_err = r_err + 9'd1;
                    end
                end
            end
            rpd_pkg::S_FILT_A: n_prod_a = 41'(w_new) * 41'(r_pw[r_idx]);
            rpd_pkg::S_FILT_B: n_prod_b = 40'(cfg.weight) * 40'(r_filt[r_idx]);
            rpd_pkg::S_FILT_C: begin
                n_filt[r_idx] = filt_sum[39:8];
                n_idx = (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
            end
            rpd_pkg::S_DECIDE: begin
                if (r_err > {1'b0, cfg.err_limit}) n_he = 1'b1;
            end
            rpd_pkg::S_MAP_SEL: begin
                if (s_f <= s_lo) begin
                    if (s_f < s_mn) begin
                        n_region = rpd_pkg::R_LOW_SAT;
                    end else begin
                        n_region = rpd_pkg::R_LOW_LIN;
                        s_xa = s_f - s_mn;
                        s_d  = s_lo - s_mn;
                    end
                end else if (s_f >= s_hi) begin
                    if (s_f > s_mx) begin
                        n_region = rpd_pkg::R_HIGH_SAT;
                    end else begin
                        n_region = rpd_pkg::R_HIGH_LIN;
                        s_xa = s_f - s_hi;
                        s_d  = s_mx - s_hi;
                    end
                end else begin
                    n_region = rpd_pkg::R_MID;
                end
                if (s_d == 34'sd0) begin
                    n_x = '0;
                    n_d = 16'd1;
                end else begin
                    n_x = s_xa[15:0];
                    n_d = s_d[15:0];
                end
                if (r_idx != 2'd0) n_span = 8'd255;
                else if (s_f <= s_lo) n_span = 8'd127;
                else n_span = 8'd128;
            end
            rpd_pkg::S_MUL: n_num = 24'(r_x) * 24'(r_span);
            rpd_pkg::S_APPLY: begin
                case (r_region)
                    rpd_pkg::R_LOW_SAT: begin
                        v_s = 10'sd127; v_b = 10'sd255;
                    end
                    rpd_pkg::R_LOW_LIN: begin
                        v_s = 10'sd127 - $signed({2'b00, quot});
                        v_b = 10'sd255 - $signed({2'b00, quot});
                    end
                    rpd_pkg::R_HIGH_LIN: begin
                        v_s = -$signed({2'b00, quot});
                        v_t = $signed({2'b00, quot});
                    end
                    rpd_pkg::R_HIGH_SAT: begin
                        v_s = -10'sd128; v_t = 10'sd255;
                    end
                    default: begin
                        v_s = '0;
                    end
                endcase
                if (r_idx == 2'd0) begin
                    if (rpd_pkg::step_over(v_s, 10'(r_hs), cfg.step_thr)) n_hs = v_s[7:0];
                    n_idx = 2'd1;
                end else begin
                    if (rpd_pkg::step_over(v_t, $signed({2'b00, r_ht}), cfg.step_thr))
                        n_ht = v_t[7:0];
                    if (rpd_pkg::step_over(v_b, $signed({2'b00, r_hb}), cfg.step_thr))
                        n_hb = v_b[7:0];
                    n_he = r_filt[2] > EM_MID;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpd_pkg::S_IDLE;
            r_rise  <= '{default: '0};
            r_pw    <= '{default: '0};
            r_filt  <= '{default: '0};
            r_fresh <= '0;
            r_err   <= '0;
            r_hs    <= '0;
            r_ht    <= '0;
            r_hb    <= '0;
            r_he    <= 1'b0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rise  <= n_rise;
            r_pw    <= n_pw;
            r_filt  <= n_filt;
            r_fresh <= n_fresh;
            r_err   <= n_err;
            r_hs    <= n_hs;
            r_ht    <= n_ht;
            r_hb    <= n_hb;
            r_he    <= n_he;
            r_idx   <= n_idx;
            if (load_out) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_a <= n_prod_a;
        r_prod_b <= n_prod_b;
        r_region <= n_region;
        r_x      <= n_x;
        r_d      <= n_d;
        r_span   <= n_span;
        r_num    <= n_num;
        if (load_out) begin
            r_os <= r_hs;
            r_ot <= r_ht;
            r_ob <= r_hb;
            r_oe <= r_he;
        end
    end

    assign o_valid     = r_ov;
    assign o_steering  = r_os;
    assign o_throttle  = r_ot;
    assign o_brake     = r_ob;
    assign o_emergency = r_oe;
endmodule

// ===== hw/rtl/rpd_cfg_regs.sv =====
// Configuration register file for the RC PWM decoder.
// Depends on rpd_pkg.
module rpd_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output rpd_pkg::t_cfg     o_cfg
);
    rpd_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= rpd_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rpd_pkg::CFG_STEER_MIN: r_cfg.steer_min <= i_cfg_data;
                rpd_pkg::CFG_STEER_MAX: r_cfg.steer_max <= i_cfg_data;
                rpd_pkg::CFG_PEDAL_MIN: r_cfg.pedal_min <= i_cfg_data;
                rpd_pkg::CFG_PEDAL_MAX: r_cfg.pedal_max <= i_cfg_data;
                rpd_pkg::CFG_MARGIN:    r_cfg.margin    <= i_cfg_data;
                rpd_pkg::CFG_ERR_LIMIT: r_cfg.err_limit <= i_cfg_data[7:0];
                rpd_pkg::CFG_STEP_THR:  r_cfg.step_thr  <= i_cfg_data[7:0];
                rpd_pkg::CFG_WEIGHT:    r_cfg.weight    <= i_cfg_data[7:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end
endmodule

// ===== hw/rtl/rpd_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// Requires numerator < denominator * 256 and a nonzero denominator. No dependencies.
module rpd_serial_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [7:0]  o_quot
);
    logic [23:0] r_rem;
    logic [22:0] r_dsr;
    logic [7:0]  r_q;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic        bit_q;

    assign bit_q  = r_rem >= {1'b0, r_dsr};
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd7;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsr <= {i_den, 7'd0};
            r_q   <= '0;
        end else if (r_busy) begin
            if (bit_q) begin
                r_rem <= r_rem - {1'b0, r_dsr};
            end
            r_dsr <= r_dsr >> 1;
            r_q   <= {r_q[6:0], bit_q};
        end
    end
endmodule

// ===== hw/rtl/rpd_checker.sv =====
// Port-level checks for the RC PWM decoder top level, with its bind.
// Depends on rc_pwm_command_decoder_top.
module rpd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              i_kind,
    input logic              o_valid,
    input logic              i_ready,
    input logic signed [7:0] o_steering,
    input logic [7:0]        o_throttle,
    input logic [7:0]        o_brake,
    input logic              o_emergency
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before transfer");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_steering) && $stable(o_throttle) &&
                                $stable(o_brake) && $stable(o_emergency))
        else $error("result changed while stalled");

    a_level_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_kind && !o_valid |=> !o_valid)
        else $error("level event produced a result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind rc_pwm_command_decoder_top rpd_checker u_rpd_checker (.*);

// ===== tb/rc_pwm_command_decoder_top_test.sv =====
// Self-checking testbench for rc_pwm_command_decoder_top: PWM edge/poll stream with a
// behavioral decoder predictor, randomized idling and stalls, config sweeps.
// Depends on rpd_pkg and the decoder RTL.
module rc_pwm_command_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EMG_LO = 1000;
    localparam int EMG_HI = 2000;
    localparam int EMG_MID = (EMG_LO + EMG_HI) / 2;
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_POLL = 1'b1;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [7:0] steering;
        logic [7:0]        throttle;
        logic [7:0]        brake;
        logic              emergency;
    } t_cmd;

    typedef struct {
        logic        kind;
        logic [1:0]  channel;
        logic        level;
        logic [31:0] time_us;
        bit          has_cmd;
        t_cmd        cmd;
    } t_row;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [2:0] i_cfg_index = rpd_pkg::CFG_STEER_MIN;
    logic [15:0] i_cfg_data = '0;
    logic i_valid = 0, o_ready;
    logic i_kind = KIND_EDGE, i_level = 0;
    logic [1:0] i_channel = '0;
    logic [31:0] i_time_us = '0;
    logic o_valid, i_ready = 0;
    logic signed [7:0] o_steering;
    logic [7:0] o_throttle, o_brake;
    logic o_emergency;

    rc_pwm_command_decoder_top dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    rpd_pkg::t_cfg cfg;
    logic [31:0] rise_t[3], width_t[3], filt_t[3];
    logic [2:0] fresh;
    int unsigned err_cnt;
    t_cmd held;
    t_cmd cmd_q[$];
    int errors = 0, n_items = 0, n_cmds = 0;
    longint cycles = 0;
    int send_idle = 0, recv_stall = 0;
    bit hold_off = 0;

    function automatic bit win(longint w, longint mn, longint mx);
        return w > mn - longint'(cfg.margin) && w < mx + longint'(cfg.margin);
    endfunction

    function automatic longint seg(longint x, longint a, longint b, longint span);
        if (b - a <= 0) return 0;
        return ((x - a) * span) / (b - a);
    endfunction

    function automatic longint ad(longint a, longint b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic void decoder_reset();
        cfg = rpd_pkg::CFG_RESET;
        for (int i = 0; i < 3; i++) begin
            rise_t[i] = 0; width_t[i] = 0; filt_t[i] = 0;
        end
        fresh = 0; err_cnt = 0; held = '0;
    endfunction

    // returns 1 and the command when the item yields one
    function automatic bit decode_item(logic kind, logic [1:0] ch, logic lvl,
                                       logic [31:0] t, output t_cmd c);
        longint half, f, mn, mx, mid, le, he, s, th, br;
        c = '0;
        if (kind == KIND_EDGE) begin
            if (ch > 2) return 0;
            if (lvl) rise_t[ch] = t;
            else begin
                width_t[ch] = t - rise_t[ch];
                fresh[ch] = 1'b1;
            end
            return 0;
        end
        if (fresh != rpd_pkg::ALL_FRESH) return 0;
        fresh = 0;
        if (win(width_t[0], cfg.steer_min, cfg.steer_max) &&
            win(width_t[1], cfg.pedal_min, cfg.pedal_max) &&
            win(width_t[2], EMG_LO, EMG_HI)) begin
            if (err_cnt > 0) err_cnt--;
        end else begin
            if (err_cnt < 2 * cfg.err_limit) err_cnt++;
            return 0;
        end
        for (int i = 0; i < 3; i++)
            filt_t[i] = 32'(((longint'(256 - cfg.weight) * width_t[i]) +
                             longint'(cfg.weight) * filt_t[i]) >> 8);
        if (err_cnt > cfg.err_limit) held.emergency = 1'b1;
        else begin
            half = cfg.margin / 2;
            f = filt_t[0]; mn = cfg.steer_min; mx = cfg.steer_max;
            mid = (mn + mx) / 2; le = mid - half; he = mid + half;
            if (f <= le) s = f < mn ? 127 : 127 - seg(f, mn, le, 127);
            else if (f >= he) s = f > mx ? -128 : -seg(f, he, mx, 128);
            else s = 0;
            if (ad(s, held.steering) > cfg.step_thr) held.steering = 8'(s);
            f = filt_t[1]; mn = cfg.pedal_min; mx = cfg.pedal_max;
            mid = (mn + mx) / 2; le = mid - half; he = mid + half;
            th = 0; br = 0;
            if (f <= le) br = f < mn ? 255 : 255 - seg(f, mn, le, 255);
            else if (f >= he) th = f > mx ? 255 : seg(f, he, mx, 255);
            if (ad(th, held.throttle) > cfg.step_thr) held.throttle = 8'(th);
            if (ad(br, held.brake) > cfg.step_thr) held.brake = 8'(br);
            held.emergency = filt_t[2] > EMG_MID;
        end
        c = held;
        return 1;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("rc_pwm_command_decoder_top_test: done, errors");
            $finish;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_cmd exp_c;
        if (i_rst_n && o_valid && i_ready) begin
            n_cmds++;
            if (cmd_q.size() == 0) begin
                $error("command transfer with nothing expected");
                errors++;
            end else begin
                exp_c = cmd_q.pop_front();
                if (o_steering !== exp_c.steering) begin
                    $error("steering exp %0d got %0d", exp_c.steering, o_steering); errors++;
                end
                if (o_throttle !== exp_c.throttle) begin
                    $error("throttle exp %0d got %0d", exp_c.throttle, o_throttle); errors++;
                end
                if (o_brake !== exp_c.brake) begin
                    $error("brake exp %0d got %0d", exp_c.brake, o_brake); errors++;
                end
                if (o_emergency !== exp_c.emergency) begin
                    $error("emergency exp %0d got %0d", exp_c.emergency, o_emergency);
                    errors++;
                end
            end
        end
        if (hold_off) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_stall);
    end

    // valid stays up after a transfer; it drops when the sender idles or drains
    task automatic send(logic kind, logic [1:0] ch, logic lvl, logic [31:0] t,
                        bit chk = 0, t_cmd want = '0);
        t_cmd c;
        i_cfg_valid <= 0;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; i_kind <= kind; i_channel <= ch; i_level <= lvl; i_time_us <= t;
        do @(posedge i_clk); while (!o_ready);
        n_items++;
        if (decode_item(kind, ch, lvl, t, c)) begin
            cmd_q.push_back(c);
            if (chk && c !== want) begin
                $error("table row: predictor %h vs typed %h", c, want); errors++;
            end
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rpd_pkg::CFG_STEER_MIN: cfg.steer_min = v;
            rpd_pkg::CFG_STEER_MAX: cfg.steer_max = v;
            rpd_pkg::CFG_PEDAL_MIN: cfg.pedal_min = v;
            rpd_pkg::CFG_PEDAL_MAX: cfg.pedal_max = v;
            rpd_pkg::CFG_MARGIN:    cfg.margin = v;
            rpd_pkg::CFG_ERR_LIMIT: cfg.err_limit = v[7:0];
            rpd_pkg::CFG_STEP_THR:  cfg.step_thr = v[7:0];
            default:                cfg.weight = v[7:0];
        endcase
    endtask

    task automatic drain();
        i_valid <= 0;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // one pulse per channel then a poll; widths random around the windows
    task automatic frame(ref logic [31:0] now, input bit good);
        logic [31:0] w;
        int lo[3], hi[3];
        lo[0] = cfg.steer_min; hi[0] = cfg.steer_max;
        lo[1] = cfg.pedal_min; hi[1] = cfg.pedal_max;
        lo[2] = EMG_LO; hi[2] = EMG_HI;
        for (int ch = 0; ch < 3; ch++) begin
            if (good && lo[ch] <= hi[ch])
                w = $urandom_range(hi[ch], lo[ch] > 0 ? lo[ch] : 0);
            else w = $urandom_range(3) == 0 ? $urandom : $urandom_range(70000);
            send(KIND_EDGE, 2'(ch), 1, now);
            send(KIND_EDGE, 2'(ch), 0, now + w);
            now = now + w + $urandom_range(500);
        end
        send(KIND_POLL, 2'($urandom_range(3)), 1'($urandom), now);
    endtask

    t_row dir[$];
    logic [31:0] now;

    function automatic t_row row(logic k, logic [1:0] ch, logic l, logic [31:0] t,
                                 bit h = 0, t_cmd c = '0);
        t_row r;
        r.kind = k; r.channel = ch; r.level = l; r.time_us = t; r.has_cmd = h; r.cmd = c;
        return r;
    endfunction

    initial begin
        decoder_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // poll before any edge, channel 3 ignored, wrapping width, full-range fields
        dir.push_back(row(KIND_POLL, 0, 0, 0));
        dir.push_back(row(KIND_EDGE, 3, 1, 32'hFFFF_FFFF));
        dir.push_back(row(KIND_EDGE, 3, 0, 32'h0));
        dir.push_back(row(KIND_EDGE, 0, 1, 32'hFFFF_FF00));
        dir.push_back(row(KIND_EDGE, 0, 0, 32'h0000_04E8)); // wraps through zero
        dir.push_back(row(KIND_EDGE, 1, 1, 100));
        dir.push_back(row(KIND_EDGE, 1, 0, 2100));
        dir.push_back(row(KIND_POLL, 3, 1, 32'hFFFF_FFFF)); // incomplete
        dir.push_back(row(KIND_EDGE, 2, 1, 5000));
        dir.push_back(row(KIND_EDGE, 2, 0, 7000));
        // full left, full brake, emergency low; filter halves from zero
        dir.push_back(row(KIND_POLL, 0, 0, 8000));
        // out-of-window steering: fails, no command
        dir.push_back(row(KIND_EDGE, 0, 1, 0));
        dir.push_back(row(KIND_EDGE, 0, 0, 32'hFFFF_FFFF));
        dir.push_back(row(KIND_EDGE, 1, 0, 3600));
        dir.push_back(row(KIND_EDGE, 2, 0, 7000));
        dir.push_back(row(KIND_POLL, 1, 0, 9000));
        foreach (dir[i])
            send(dir[i].kind, dir[i].channel, dir[i].level, dir[i].time_us,
                 dir[i].has_cmd, dir[i].cmd);
        drain();

        // raw filter, zero threshold: exact extremes
        write_reg(rpd_pkg::CFG_WEIGHT, 0);
        write_reg(rpd_pkg::CFG_STEP_THR, 0);
        now = 10000;
        send(KIND_EDGE, 0, 1, now); send(KIND_EDGE, 0, 0, now + 950);
        send(KIND_EDGE, 1, 1, now); send(KIND_EDGE, 1, 0, now + 2050);
        send(KIND_EDGE, 2, 1, now); send(KIND_EDGE, 2, 0, now + 1999);
        send(KIND_POLL, 0, 0, now, 1, '{8'sd127, 8'd255, 8'd0, 1'b1});
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 72; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 72; end
                default: begin send_idle = 18; recv_stall = 18; end
            endcase
            case (ph)
                0: ;
                1: begin
                    write_reg(rpd_pkg::CFG_STEER_MIN, 0);
                    write_reg(rpd_pkg::CFG_STEER_MAX, 65535);
                    write_reg(rpd_pkg::CFG_MARGIN, 0);
                    write_reg(rpd_pkg::CFG_ERR_LIMIT, 0);
                    write_reg(rpd_pkg::CFG_STEP_THR, 255);
                    write_reg(rpd_pkg::CFG_WEIGHT, 255);
                end
                2: begin
                    write_reg(rpd_pkg::CFG_PEDAL_MIN, 65535);
                    write_reg(rpd_pkg::CFG_PEDAL_MAX, 0);
                    write_reg(rpd_pkg::CFG_MARGIN, 65535);
                    write_reg(rpd_pkg::CFG_ERR_LIMIT, 255);
                end
                3: begin
                    write_reg(rpd_pkg::CFG_STEER_MIN, 1500);
                    write_reg(rpd_pkg::CFG_STEER_MAX, 1500);
                    write_reg(rpd_pkg::CFG_PEDAL_MIN, 900);
                    write_reg(rpd_pkg::CFG_PEDAL_MAX, 2100);
                    write_reg(rpd_pkg::CFG_MARGIN, 300);
                    write_reg(rpd_pkg::CFG_STEP_THR, 0);
                    write_reg(rpd_pkg::CFG_WEIGHT, 0);
                    write_reg(rpd_pkg::CFG_ERR_LIMIT, 3);
                end
                default: for (int r = 0; r < 8; r++) begin
                    if (r < 4) write_reg(3'(r), 16'($urandom_range(2500, 500)));
                    else if (r == 4) write_reg(3'(r), 16'($urandom_range(400)));
                    else write_reg(3'(r), 16'($urandom));
                end
            endcase
            if (ph == 2) fork
                begin hold_off = 1; repeat (600) @(posedge i_clk); hold_off = 0; end
            join_none
            for (int k = 0; k < 18; k++) begin
                int r;
                r = $urandom_range(9);
                if (r < 7) frame(now, r < 6);
                else send(1'($urandom), 2'($urandom), 1'($urandom), $urandom);
            end
            drain();
        end
        $display("rc_pwm_command_decoder_top_test: %0d items, %0d commands over 8 config sets",
                 n_items, n_cmds);
        if (errors == 0) $display("rc_pwm_command_decoder_top_test: done, clean");
        else $display("rc_pwm_command_decoder_top_test: done, errors");
        $finish;
    end
endmodule
